/* design/plane_pair_intersection_top_macros.svh */
// ----------------------------------------------------------------------------
// plane pair intersection assertion macros
// concurrent check wrappers that drop out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef PLANE_PAIR_INTERSECTION_TOP_MACROS_SVH
`define PLANE_PAIR_INTERSECTION_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PPI_ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// next-cycle implication
`define PPI_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define PPI_ASSERT_IMPLY(label, clk, rst, pre, post, msg)
`define PPI_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

/* design/ppi_pkg.sv */
// ----------------------------------------------------------------------------
// ppi_pkg
// types and constants shared by the plane pair intersection pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ppi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QUO_W     = 32;
  localparam int DET_W     = 128;
  localparam int MAG_W     = 128;
  localparam int REM_W     = DET_W + QUO_W;
  localparam int K_W       = 98;
  localparam int NUM_W     = 130;
  localparam int DIV_CELLS = QUO_W;

  localparam logic [64:0] HALF_LSB = 65'(1) << (FRAC_BITS - 1);
  localparam logic [32:0] LIM_POS  = 33'h0_7FFF_FFFF;
  localparam logic [32:0] LIM_NEG  = 33'h0_8000_0000;

  typedef struct packed {
    logic signed [31:0] first_normal_x;
    logic signed [31:0] first_normal_y;
    logic signed [31:0] first_normal_z;
    logic signed [31:0] first_offset;
    logic signed [31:0] second_normal_x;
    logic signed [31:0] second_normal_y;
    logic signed [31:0] second_normal_z;
    logic signed [31:0] second_offset;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] direction_x;
    logic signed [31:0] direction_y;
    logic signed [31:0] direction_z;
    logic               parallel;
    logic               saturated;
  } out_item_t;

  // state handed from one divider cell to the next
  typedef struct packed {
    logic                        valid;
    logic [2:0][REM_W-1:0]       rem;
    logic [REM_W-1:0]            dsh;
    logic [2:0][QUO_W-1:0]       quo;
    logic [2:0]                  neg;
    logic [2:0]                  ovf;
    logic [2:0][31:0]            dir;
    logic                        dir_sat;
    logic                        par;
  } div_t;

endpackage

/* design/ppi_front.sv */
// ----------------------------------------------------------------------------
// ppi_front
// products, dot sums, determinant, scale factors and numerators ahead of
// the divider chain; also finishes the rounded direction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ppi_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             req_valid,
  input  ppi_pkg::in_item_t req,
  output ppi_pkg::div_t    start
);
  import ppi_pkg::*;

  // stage 1: input register
  logic     v1;
  in_item_t it1;
  logic signed [31:0] n1 [3];
  logic signed [31:0] n2 [3];

  // stage 2: 32x32 products
  logic v2;
  logic signed [63:0] cra2 [3];
  logic signed [63:0] crb2 [3];
  logic signed [63:0] sq1_2 [3];
  logic signed [63:0] sq2_2 [3];
  logic signed [63:0] pr_2 [3];
  logic signed [31:0] n1_2 [3];
  logic signed [31:0] n2_2 [3];
  logic signed [31:0] d1_2, d2_2;

  // stage 3: cross product and dot sums
  logic v3;
  logic signed [64:0] c3 [3];
  logic [63:0]        a11_3, a22_3;
  logic signed [65:0] a12_3;
  logic signed [31:0] n1_3 [3];
  logic signed [31:0] n2_3 [3];
  logic signed [31:0] d1_3, d2_3;

  // stage 4: cross magnitudes and scale factor partials
  logic v4;
  logic [63:0]        cm4 [3];
  logic [2:0]         cn4;
  logic signed [65:0] k1p4 [4];
  logic signed [65:0] k2p4 [4];
  logic signed [31:0] n1_4 [3];
  logic signed [31:0] n2_4 [3];

  // stage 5: squares of the cross product, scale factors, direction
  logic v5;
  logic [63:0]          hh5 [3];
  logic [63:0]          hl5 [3];
  logic [63:0]          ll5 [3];
  logic signed [K_W-1:0] k1_5, k2_5;
  logic [2:0][31:0]     dir5;
  logic                 dsat5;
  logic signed [31:0]   n1_5 [3];
  logic signed [31:0]   n2_5 [3];
  logic [2:0][31:0]     dir_calc;
  logic [2:0]           dsat_calc;

  // stage 6: determinant and numerator partials
  logic v6;
  logic [DET_W-1:0]   det6;
  logic [DET_W-1:0]   det_sum;
  logic signed [65:0] pl1_6 [3];
  logic signed [65:0] pm1_6 [3];
  logic signed [65:0] ph1_6 [3];
  logic signed [65:0] pl2_6 [3];
  logic signed [65:0] pm2_6 [3];
  logic signed [65:0] ph2_6 [3];
  logic [2:0][31:0]   dir6;
  logic               dsat6;

  // stage 7: numerators
  logic v7;
  logic signed [NUM_W-1:0] num7 [3];
  logic [DET_W-1:0]        det7;
  logic                    par7;
  logic [2:0][31:0]        dir7;
  logic                    dsat7;

  // stage 8: sign and magnitude into divider form
  div_t pre8;
  div_t pre_calc;
  div_t start_calc;

  assign n1[0] = it1.first_normal_x;
  assign n1[1] = it1.first_normal_y;
  assign n1[2] = it1.first_normal_z;
  assign n2[0] = it1.second_normal_x;
  assign n2[1] = it1.second_normal_y;
  assign n2[2] = it1.second_normal_z;

  // direction rounding to nearest, ties away from zero, with clamp
  always_comb begin
    logic [64:0] rnd;
    logic [64:0] qd;
    logic [32:0] lim;
    logic [31:0] val;
    rnd = '0;
    qd  = '0;
    lim = '0;
    val = '0;
    for (int i = 0; i < 3; i++) begin
      rnd          = {1'b0, cm4[i]} + HALF_LSB;
      qd           = rnd >> FRAC_BITS;
      lim          = cn4[i] ? LIM_NEG : LIM_POS;
      dsat_calc[i] = (qd > 65'(lim));
      val          = dsat_calc[i] ? lim[31:0] : qd[31:0];
      dir_calc[i]  = cn4[i] ? (32'd0 - val) : val;
    end
  end

  // determinant as the squared length of the cross product
  always_comb begin
    det_sum = '0;
    for (int i = 0; i < 3; i++) begin
      det_sum = det_sum + {hh5[i], 64'd0} + (DET_W'(hl5[i]) << 33) + DET_W'(ll5[i]);
    end
  end

  // divider entry form
  always_comb begin
    logic [NUM_W-1:0] absn;
    absn           = '0;
    pre_calc       = '0;
    pre_calc.valid = v7;
    pre_calc.dsh   = {det7, {QUO_W{1'b0}}};
    pre_calc.dir   = dir7;
    pre_calc.dir_sat = dsat7;
    pre_calc.par   = par7;
    for (int i = 0; i < 3; i++) begin
      pre_calc.neg[i] = num7[i][NUM_W-1];
      absn            = num7[i][NUM_W-1] ? NUM_W'(-num7[i]) : NUM_W'(num7[i]);
      pre_calc.rem[i] = REM_W'({absn[MAG_W-1:0], {FRAC_BITS{1'b0}}});
    end
  end

  // quotient would reach 2^32 or more
  always_comb begin
    start_calc = pre8;
    for (int i = 0; i < 3; i++) begin
      start_calc.ovf[i] = (pre8.rem[i] >= pre8.dsh);
    end
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      pre8.valid  <= 1'b0;
      start.valid <= 1'b0;
    end else if (adv) begin
      v1  <= req_valid;
      it1 <= req;

      v2 <= v1;
      cra2[0] <= n1[1] * n2[2];
      crb2[0] <= n1[2] * n2[1];
      cra2[1] <= n1[2] * n2[0];
      crb2[1] <= n1[0] * n2[2];
      cra2[2] <= n1[0] * n2[1];
      crb2[2] <= n1[1] * n2[0];
      for (int i = 0; i < 3; i++) begin
        sq1_2[i] <= n1[i] * n1[i];
        sq2_2[i] <= n2[i] * n2[i];
        pr_2[i]  <= n1[i] * n2[i];
        n1_2[i]  <= n1[i];
        n2_2[i]  <= n2[i];
      end
      d1_2 <= it1.first_offset;
      d2_2 <= it1.second_offset;

      v3 <= v2;
      for (int i = 0; i < 3; i++) begin
        c3[i]   <= 65'(cra2[i]) - 65'(crb2[i]);
        n1_3[i] <= n1_2[i];
        n2_3[i] <= n2_2[i];
      end
      a11_3 <= $unsigned(sq1_2[0] + sq1_2[1] + sq1_2[2]);
      a22_3 <= $unsigned(sq2_2[0] + sq2_2[1] + sq2_2[2]);
      a12_3 <= 66'(pr_2[0]) + 66'(pr_2[1]) + 66'(pr_2[2]);
      d1_3  <= d1_2;
      d2_3  <= d2_2;

      v4 <= v3;
      for (int i = 0; i < 3; i++) begin
        cn4[i]  <= c3[i][64];
        cm4[i]  <= c3[i][64] ? 64'(-c3[i]) : c3[i][63:0];
        n1_4[i] <= n1_3[i];
        n2_4[i] <= n2_3[i];
      end
      k1p4[0] <= d1_3 * $signed({1'b0, a22_3[31:0]});
      k1p4[1] <= d1_3 * $signed({1'b0, a22_3[63:32]});
      k1p4[2] <= d2_3 * $signed({1'b0, a12_3[31:0]});
      k1p4[3] <= d2_3 * $signed(a12_3[65:32]);
      k2p4[0] <= d2_3 * $signed({1'b0, a11_3[31:0]});
      k2p4[1] <= d2_3 * $signed({1'b0, a11_3[63:32]});
      k2p4[2] <= d1_3 * $signed({1'b0, a12_3[31:0]});
      k2p4[3] <= d1_3 * $signed(a12_3[65:32]);

      v5 <= v4;
      for (int i = 0; i < 3; i++) begin
        hh5[i]  <= cm4[i][63:32] * cm4[i][63:32];
        hl5[i]  <= cm4[i][63:32] * cm4[i][31:0];
        ll5[i]  <= cm4[i][31:0] * cm4[i][31:0];
        n1_5[i] <= n1_4[i];
        n2_5[i] <= n2_4[i];
      end
      k1_5  <= K_W'(k1p4[0]) + (K_W'(k1p4[1]) << 32)
             - K_W'(k1p4[2]) - (K_W'(k1p4[3]) << 32);
      k2_5  <= K_W'(k2p4[0]) + (K_W'(k2p4[1]) << 32)
             - K_W'(k2p4[2]) - (K_W'(k2p4[3]) << 32);
      dir5  <= dir_calc;
      dsat5 <= |dsat_calc;

      v6 <= v5;
      det6 <= det_sum;
      for (int i = 0; i < 3; i++) begin
        pl1_6[i] <= n1_5[i] * $signed({1'b0, k1_5[31:0]});
        pm1_6[i] <= n1_5[i] * $signed({1'b0, k1_5[63:32]});
        ph1_6[i] <= n1_5[i] * $signed(k1_5[K_W-1:64]);
        pl2_6[i] <= n2_5[i] * $signed({1'b0, k2_5[31:0]});
        pm2_6[i] <= n2_5[i] * $signed({1'b0, k2_5[63:32]});
        ph2_6[i] <= n2_5[i] * $signed(k2_5[K_W-1:64]);
      end
      dir6  <= dir5;
      dsat6 <= dsat5;

      v7 <= v6;
      for (int i = 0; i < 3; i++) begin
        num7[i] <= NUM_W'(pl1_6[i]) + (NUM_W'(pm1_6[i]) << 32) + (NUM_W'(ph1_6[i]) << 64)
                 + NUM_W'(pl2_6[i]) + (NUM_W'(pm2_6[i]) << 32) + (NUM_W'(ph2_6[i]) << 64);
      end
      det7  <= det6;
      par7  <= (det6 == '0);
      dir7  <= dir6;
      dsat7 <= dsat6;

      pre8 <= pre_calc;

      start <= start_calc;
    end
  end

endmodule

/* design/ppi_div_cell.sv */
// ----------------------------------------------------------------------------
// ppi_div_cell
// one restoring division step for the three point lanes, one quotient bit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ppi_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  ppi_pkg::div_t cur,
  output ppi_pkg::div_t nxt
);
  import ppi_pkg::*;

  div_t             step;
  logic [REM_W-1:0] trial;

  // compare against the halved divisor and subtract where it fits
  always_comb begin
    step     = cur;
    trial    = cur.dsh >> 1;
    step.dsh = trial;
    for (int i = 0; i < 3; i++) begin
      if (cur.rem[i] >= trial) begin
        step.rem[i] = cur.rem[i] - trial;
        step.quo[i] = {cur.quo[i][QUO_W-2:0], 1'b1};
      end else begin
        step.quo[i] = {cur.quo[i][QUO_W-2:0], 1'b0};
      end
    end
  end

  // hand to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      nxt.valid <= 1'b0;
    end else if (adv) begin
      nxt <= step;
    end
  end

endmodule

/* design/ppi_back.sv */
// ----------------------------------------------------------------------------
// ppi_back
// rounds and clamps the quotients and assembles the result item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ppi_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  ppi_pkg::div_t     fin,
  output logic              done_valid,
  output ppi_pkg::out_item_t done_item
);
  import ppi_pkg::*;

  logic             vb;
  logic [32:0]      q1 [3];
  logic [2:0]       negb, ovfb;
  logic [2:0][31:0] dirb;
  logic             dsatb, parb;
  logic [32:0]      q1_calc [3];
  out_item_t        item_calc;

  // round up when the remainder is at least half the divisor
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q1_calc[i] = {1'b0, fin.quo[i]}
                 + 33'({fin.rem[i], 1'b0} >= {1'b0, fin.dsh});
    end
  end

  // clamp, restore sign, zero the point on parallel planes
  always_comb begin
    logic [32:0]      lim;
    logic [31:0]      val;
    logic [2:0]       sat;
    logic [2:0][31:0] pt;
    lim = '0;
    val = '0;
    for (int i = 0; i < 3; i++) begin
      lim    = negb[i] ? LIM_NEG : LIM_POS;
      sat[i] = ovfb[i] || (q1[i] > lim);
      val    = sat[i] ? lim[31:0] : q1[i][31:0];
      pt[i]  = parb ? 32'd0 : (negb[i] ? (32'd0 - val) : val);
    end
    item_calc.point_x     = pt[0];
    item_calc.point_y     = pt[1];
    item_calc.point_z     = pt[2];
    item_calc.direction_x = dirb[0];
    item_calc.direction_y = dirb[1];
    item_calc.direction_z = dirb[2];
    item_calc.parallel    = parb;
    item_calc.saturated   = dsatb || (!parb && (|sat));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb         <= 1'b0;
      done_valid <= 1'b0;
    end else if (adv) begin
      vb    <= fin.valid;
      q1    <= q1_calc;
      negb  <= fin.neg;
      ovfb  <= fin.ovf;
      dirb  <= fin.dir;
      dsatb <= fin.dir_sat;
      parb  <= fin.par;
      done_valid <= vb;
      done_item  <= item_calc;
    end
  end

endmodule

/* design/plane_pair_intersection_top.sv */
// ----------------------------------------------------------------------------
// plane_pair_intersection_top
// intersection line of two planes in signed Q16.16: point and direction
// ----------------------------------------------------------------------------
//  channel | signals                      | carries
//  req     | req_valid req_ready req      | two planes, normal and offset each
//  res     | res_valid res_ready res      | line point, direction, flags
//
//  one plane pair per cycle while the output buffer has room; an input
//  transfer runs through the product stages and the 32-cell divider chain
//  reset clears the valid bits and the two-entry output buffer only
//  the whole pipeline holds while the output buffer is full
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "plane_pair_intersection_top_macros.svh"
module plane_pair_intersection_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  ppi_pkg::in_item_t  req,
  output logic               res_valid,
  input  logic               res_ready,
  output ppi_pkg::out_item_t res
);
  import ppi_pkg::*;

  logic      adv;
  div_t      chain [DIV_CELLS+1];
  logic      done_valid;
  out_item_t done_item;

  out_item_t obuf [2];
  logic      wr_ptr, rd_ptr;
  logic [1:0] count, count_next;
  logic      push, pop;

  // pipeline moves whenever the output buffer has room
  assign adv       = (count != 2'd2);
  assign req_ready = adv;

  ppi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .req_valid (req_valid),
    .req       (req),
    .start     (chain[0])
  );

  // divider cells, one quotient bit each
  for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
    ppi_div_cell u_cell (
      .clk (clk),
      .rst (rst),
      .adv (adv),
      .cur (chain[g]),
      .nxt (chain[g+1])
    );
  end

  ppi_back u_back (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .fin        (chain[DIV_CELLS]),
    .done_valid (done_valid),
    .done_item  (done_item)
  );

  // output buffer
  assign push       = adv && done_valid;
  assign pop        = res_valid && res_ready;
  assign res_valid  = (count != 2'd0);
  assign res        = obuf[rd_ptr];
  assign count_next = count + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        obuf[wr_ptr] <= done_item;
        wr_ptr       <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  // checks
  `PPI_ASSERT_IMPLY(a_full_stalls, clk, rst, count == 2'd2, !req_ready, "input taken while buffer full")
  `PPI_ASSERT_IMPLY(a_par_zero, clk, rst, res_valid && res.parallel, (res.point_x == 32'd0) && (res.point_y == 32'd0) && (res.point_z == 32'd0), "parallel result with nonzero point")
  `PPI_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 2'd1, "buffer count lost a transfer")

endmodule
